@@ rtl/pose_velocity_spike_median_filter_defines.svh @@
// Assertion macros for the pose velocity spike median filter.
`ifndef POSE_VELOCITY_SPIKE_MEDIAN_FILTER_DEFINES_SVH
`define POSE_VELOCITY_SPIKE_MEDIAN_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define PVSM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pvsm assertion failed");
`define PVSM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pvsm assertion failed");
`else
`define PVSM_ASSERT(label, clk, rst_n, prop)
`define PVSM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/pvsm_pkg.sv @@
// Types and constants shared by the pose velocity spike median filter.
package pvsm_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int SPEED_W = 52;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RATIO_LIMIT = 2'd1;

    localparam logic [4:0] WINDOW_LENGTH_RST = 5'd16;
    localparam logic [15:0] SPEED_RATIO_RST = 16'd768;

    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    typedef struct packed {
        logic [31:0] time_us;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } t_pose_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] out_heading;
        logic median_used;
    } t_pose_out;

endpackage

@@ rtl/pvsm_ring.sv @@
// Pose ring memory: one write port, one registered read port.
module pvsm_ring
    import pvsm_pkg::*;
#(
    parameter int DEPTH = WINDOW_MAX_DEF,
    parameter int AW = $clog2(WINDOW_MAX_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_pose_in      i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_pose_in      o_rdata
);

    t_pose_in r_mem [DEPTH];
    t_pose_in r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pvsm_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module pvsm_sqrt
    import pvsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_v;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] rem2;
    logic [34:0] trial;

    assign rem2  = {r_rem[32:0], r_v[63:62]};
    assign trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v <= {r_v[61:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/pvsm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pvsm_div
    import pvsm_pkg::*;
#(
    parameter int NUM_W = SPEED_W + 4,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;

    assign sh   = {r_rem, r_q[NUM_W-1]};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                r_rem <= diff[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/pose_velocity_spike_median_filter.sv @@
// Top level: pose ring, speed walk, spike test and window median.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_pose_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_pose_out)
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// Work per item with n poses in the window: with n < 2 the item goes straight
// to the output; otherwise a pair walk (square root and divider per pair) and
// the average division, plus the median count walk over the single read port
// of the ring when a spike is found.
// Synchronous active-low reset clears the window; ring contents stay unknown.
// The input stalls while an item is being worked; a stalled output holds its
// item, and the next input item is taken while it waits.
`include "pose_velocity_spike_median_filter_defines.svh"
module pose_velocity_spike_median_filter
    import pvsm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pose_in              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_pose_out             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = SPEED_W + AW;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_RD0    = 20'h00002,
        S_CAP0   = 20'h00004,
        S_RD1    = 20'h00008,
        S_CAP1   = 20'h00010,
        S_SQX    = 20'h00020,
        S_SQY    = 20'h00040,
        S_SQRT   = 20'h00080,
        S_MUL    = 20'h00100,
        S_DIV    = 20'h00200,
        S_ACC    = 20'h00400,
        S_AVG    = 20'h00800,
        S_THR    = 20'h01000,
        S_CMP    = 20'h02000,
        S_MC_RD  = 20'h04000,
        S_MC_CAP = 20'h08000,
        S_MJ_RD  = 20'h10000,
        S_MJ_CAP = 20'h20000,
        S_MEVAL  = 20'h40000,
        S_DONE   = 20'h80000
    } t_state;

    t_state r_state;

    logic [4:0]  r_wl;
    logic [15:0] r_lim;
    logic [AW-1:0] r_slot;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_oldest;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_cptr;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_j;

    t_pose_in  r_prev;
    t_pose_in  r_cur;
    t_pose_in  r_cand;
    t_pose_out r_res;
    t_pose_out r_out;
    logic      r_out_valid;

    logic [31:0] r_ay;
    logic [31:0] r_dt;
    logic [63:0] r_sqx;
    logic [63:0] r_sq;
    logic [SPEED_W-1:0] r_speed;
    logic [SW-1:0] r_sum;
    logic [68:0] r_prod;
    logic        r_sqrt_start;
    logic        r_div_start;
    logic [SW-1:0] r_div_num;
    logic [31:0] r_div_den;

    logic [CW-1:0] r_ltx, r_lex, r_lty, r_ley, r_lth, r_leh;

    logic [CW-1:0] eff_w;
    logic [CW:0]   fill_inc;
    logic [CW-1:0] n_cnt;
    logic [AW-1:0] slot_next;
    logic [7:0]    old_sum;
    logic          accept;
    logic          pair_last;
    logic          out_free;
    logic          re;
    logic [AW-1:0] raddr;
    t_pose_in      rdata;
    logic          sqrt_done;
    logic [31:0]   sqrt_root;
    logic          div_done;
    logic [SW-1:0] div_quot;
    logic [32:0]   dx;
    logic [32:0]   dy;
    logic [32:0]   mx;
    logic [32:0]   my;
    logic [SPEED_W-1:0] cur_speed;
    logic [CW-1:0] med_idx;
    logic [SPEED_W:0] den;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        wrap_inc = (a == AW'(WINDOW_MAX - 1)) ? '0 : a + AW'(1);
    endfunction

    // effective window: zero reads as one, large values clip to the ring depth
    always_comb begin
        if (r_wl == 5'd0) begin
            eff_w = CW'(1);
        end else if (int'(r_wl) > WINDOW_MAX) begin
            eff_w = CW'(WINDOW_MAX);
        end else begin
            eff_w = CW'(r_wl);
        end
    end

    assign accept    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign fill_inc  = {1'b0, r_fill} + (CW+1)'(1);
    assign n_cnt     = (fill_inc > {1'b0, eff_w}) ? eff_w : fill_inc[CW-1:0];
    assign slot_next = wrap_inc(r_slot);
    assign old_sum   = 8'(slot_next) + 8'(WINDOW_MAX) - 8'(n_cnt);
    assign med_idx   = r_fill >> 1;
    assign pair_last = (r_k + CW'(1) == r_fill - CW'(1));
    assign out_free  = !r_out_valid || !i_out_stall;

    assign dx = {r_cur.pos_x[31], r_cur.pos_x} - {r_prev.pos_x[31], r_prev.pos_x};
    assign dy = {r_cur.pos_y[31], r_cur.pos_y} - {r_prev.pos_y[31], r_prev.pos_y};
    assign mx = dx[32] ? (~dx + 33'd1) : dx;
    assign my = dy[32] ? (~dy + 33'd1) : dy;

    assign cur_speed = (r_dt == 32'd0) ? SPEED_MAX : div_quot[SPEED_W-1:0];
    assign den       = {1'b0, div_quot[SPEED_W-1:0]} + (SPEED_W+1)'(1);

    always_comb begin
        re    = 1'b0;
        raddr = r_ptr;
        unique case (r_state)
            S_RD0, S_RD1: begin
                re = 1'b1;
            end
            S_MC_RD: begin
                re    = 1'b1;
                raddr = r_cptr;
            end
            S_MJ_RD: begin
                re = 1'b1;
            end
            default: begin
                re = 1'b0;
            end
        endcase
    end

    pvsm_ring #(.DEPTH(WINDOW_MAX), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_slot),
        .i_wdata (i_in_item),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pvsm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_value (r_sq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    pvsm_div #(.NUM_W(SW), .DEN_W(32)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl  <= WINDOW_LENGTH_RST;
            r_lim <= SPEED_RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LENGTH:     r_wl  <= i_cfg_data[4:0];
                CFG_SPEED_RATIO_LIMIT: r_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            r_sqrt_start <= (r_state == S_SQY);
            // a zero time step saturates, so skip the divider
            r_div_start  <= ((r_state == S_MUL) && (r_dt != 32'd0)) ||
                            ((r_state == S_ACC) && pair_last);
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_slot <= slot_next;
                        r_fill <= n_cnt;
                        r_state <= (n_cnt < CW'(2)) ? S_DONE : S_RD0;
                    end
                end
                S_RD0:    r_state <= S_CAP0;
                S_CAP0:   r_state <= S_RD1;
                S_RD1:    r_state <= S_CAP1;
                S_CAP1:   r_state <= S_SQX;
                S_SQX:    r_state <= S_SQY;
                S_SQY:    r_state <= S_SQRT;
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= (r_dt != 32'd0) ? S_DIV : S_ACC;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_state <= pair_last ? S_AVG : S_RD1;
                end
                S_AVG: begin
                    if (div_done) begin
                        r_state <= S_THR;
                    end
                end
                S_THR:    r_state <= S_CMP;
                S_CMP: begin
                    r_state <= ({r_speed, 8'd0} > r_prod) ? S_MC_RD : S_DONE;
                end
                S_MC_RD:  r_state <= S_MC_CAP;
                S_MC_CAP: r_state <= S_MJ_RD;
                S_MJ_RD:  r_state <= S_MJ_CAP;
                S_MJ_CAP: begin
                    r_state <= (r_j + CW'(1) == r_fill) ? S_MEVAL : S_MJ_RD;
                end
                S_MEVAL: begin
                    r_state <= (r_k + CW'(1) == r_fill) ? S_DONE : S_MC_RD;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_res    <= '{out_x: i_in_item.pos_x, out_y: i_in_item.pos_y,
                              out_heading: i_in_item.heading, median_used: 1'b0};
                r_oldest <= (old_sum >= 8'(WINDOW_MAX)) ? AW'(old_sum - 8'(WINDOW_MAX))
                                                         : AW'(old_sum);
                r_ptr    <= (old_sum >= 8'(WINDOW_MAX)) ? AW'(old_sum - 8'(WINDOW_MAX))
                                                         : AW'(old_sum);
                r_k      <= '0;
                r_sum    <= '0;
            end
            S_CAP0: begin
                r_prev <= rdata;
                r_ptr  <= wrap_inc(r_ptr);
            end
            S_CAP1: begin
                r_cur <= rdata;
            end
            S_SQX: begin
                r_ay  <= my[32:1];
                r_dt  <= r_cur.time_us - r_prev.time_us;
                r_sqx <= 64'(mx[32:1]) * 64'(mx[32:1]);
            end
            S_SQY: begin
                r_sq <= r_sqx + 64'(r_ay) * 64'(r_ay);
            end
            S_MUL: begin
                r_div_num <= SW'(52'(sqrt_root) * 52'(US_PER_S));
                r_div_den <= r_dt;
            end
            S_ACC: begin
                r_speed   <= cur_speed;
                r_sum     <= r_sum + SW'(cur_speed);
                r_div_num <= r_sum + SW'(cur_speed);
                r_div_den <= 32'(r_fill - CW'(1));
                r_k       <= r_k + CW'(1);
                r_prev    <= r_cur;
                r_ptr     <= wrap_inc(r_ptr);
            end
            S_THR: begin
                r_prod <= 69'(r_lim) * 69'(den);
                r_k    <= '0;
                r_cptr <= r_oldest;
            end
            S_MC_CAP: begin
                r_cand <= rdata;
                r_ptr  <= r_oldest;
                r_j    <= '0;
                r_ltx <= '0; r_lex <= '0;
                r_lty <= '0; r_ley <= '0;
                r_lth <= '0; r_leh <= '0;
            end
            S_MJ_CAP: begin
                // count window entries below and not above the candidate
                if (rdata.pos_x < r_cand.pos_x) r_ltx <= r_ltx + CW'(1);
                if (rdata.pos_x <= r_cand.pos_x) r_lex <= r_lex + CW'(1);
                if (rdata.pos_y < r_cand.pos_y) r_lty <= r_lty + CW'(1);
                if (rdata.pos_y <= r_cand.pos_y) r_ley <= r_ley + CW'(1);
                if (rdata.heading < r_cand.heading) r_lth <= r_lth + CW'(1);
                if (rdata.heading <= r_cand.heading) r_leh <= r_leh + CW'(1);
                r_j   <= r_j + CW'(1);
                r_ptr <= wrap_inc(r_ptr);
            end
            S_MEVAL: begin
                r_res.median_used <= 1'b1;
                if (r_ltx <= med_idx && med_idx < r_lex) r_res.out_x <= r_cand.pos_x;
                if (r_lty <= med_idx && med_idx < r_ley) r_res.out_y <= r_cand.pos_y;
                if (r_lth <= med_idx && med_idx < r_leh) r_res.out_heading <= r_cand.heading;
                r_k    <= r_k + CW'(1);
                r_cptr <= wrap_inc(r_cptr);
            end
            S_DONE: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `PVSM_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(WINDOW_MAX))
    `PVSM_ASSERT(a_fill_after_accept, i_clk, i_rst_n, accept |=> r_fill != '0)
    `PVSM_ASSERT(a_slot_range, i_clk, i_rst_n, int'(r_slot) < WINDOW_MAX)
    `PVSM_ASSERT(a_walk_needs_pairs, i_clk, i_rst_n, r_state == S_RD0 |-> r_fill >= CW'(2))

endmodule
